[design/ablm_pkg.sv]
package ablm_pkg;
    localparam int SAMPLE_W = 16;
    localparam int STATE_W  = 36;
    localparam int SUM_W    = 48;
    localparam int FLOOR_W  = 10;
    localparam int LEVEL_W  = 8;
    localparam int NBANDS   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int LOGQ_W   = 24;

    localparam logic [16:0] K_DC   = 17'd328;
    localparam logic [16:0] K_BASS = 17'd6160;
    localparam logic [16:0] K_MID  = 17'd21496;
    localparam logic [16:0] K_HI   = 17'd51905;
    localparam logic [23:0] LOG2_1E4_Q16 = 24'd870824;

    // floor(2^40 / 870824), the estimate is low by at most one
    localparam logic [20:0] LVL_RECIP    = 21'd1262610;
    localparam int          LVL_RECIP_SH = 40;

    localparam logic [FLOOR_W-1:0] FLOOR_RST [NBANDS] = '{
        10'd7, 10'd4, 10'd5, 10'd6, 10'd8};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       block_end;
    } t_item;

    typedef logic [LEVEL_W-1:0] t_levels [NBANDS];
endpackage

[design/ablm_fifo.sv]
module ablm_fifo import ablm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_data
);
    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

[design/ablm_filter.sv]
// sequential filter, accumulate and level engine; the DC and low-pass steps share one multiplier
module ablm_filter import ablm_pkg::*; #(
    parameter int BLOCK_MAX = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  t_item               i_item,
    output logic                o_busy,
    input  logic [FLOOR_W-1:0]  i_floor [NBANDS],
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output t_levels             o_levels
);
    localparam int CNT_W = $clog2(BLOCK_MAX + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_DC = 4'd1, S_LP = 4'd2, S_ACC = 4'd3,
        S_LOGS = 4'd4, S_LOGI = 4'd5, S_LVL = 4'd6, S_DIV = 4'd7, S_OUT = 4'd8,
        S_SMTH = 4'd9;

    logic [3:0]                  r_st;
    logic signed [SAMPLE_W-1:0]  r_smp;
    logic signed [STATE_W-1:0]   r_dc, r_ac;
    logic signed [STATE_W-1:0]   r_lp [3];
    logic [SUM_W-1:0]            r_sum [NBANDS];
    logic [CNT_W-1:0]            r_cnt;
    logic [LEVEL_W-1:0]          r_sm [NBANDS];
    logic [2:0]                  r_idx;
    logic                        r_last;
    logic [4:0]                  r_it;
    logic [31:0]                 r_m;
    logic [LOGQ_W-1:0]           r_lr;
    logic [1:0]                  r_lsel;
    logic signed [LOGQ_W+1:0]    r_d;
    logic [LOGQ_W-1:0]           r_lsum, r_lcnt;
    logic [33:0]                 r_num;
    logic [9:0]                  r_q;
    logic [LEVEL_W-1:0]          r_lv [NBANDS];
    logic                        r_outv;

    logic signed [STATE_W-1:0] w_x, w_y, w_sig, w_r;
    logic signed [STATE_W+17:0] w_prod;
    logic signed [16:0]         w_k;
    logic [63:0]                w_v;
    logic [5:0]                 w_p;
    logic [31:0]                w_m0;
    logic [63:0]                w_sq;
    logic [SUM_W:0]             w_acc;
    logic [FLOOR_W-1:0]         w_fl;
    logic [54:0]                w_qprod;
    logic [9:0]                 w_qest;
    logic [33:0]                w_rem;
    logic                       w_emit;

    assign o_busy      = (r_st != S_IDLE);
    assign o_res_valid = r_outv;
    assign o_levels    = r_sm;

    // final level step waits until the previous result has left
    assign w_emit = (r_st == S_SMTH) && (r_idx == 3'(NBANDS-1)) && (!r_outv || i_res_ready);

    always_comb begin
        w_y = r_dc;
        w_x = {{(STATE_W-SAMPLE_W){r_smp[SAMPLE_W-1]}}, r_smp} <<< 16;
        w_k = K_DC;
        if (r_st == S_LP) begin
            w_x = r_ac;
            w_y = r_lp[r_idx[1:0]];
            case (r_idx[1:0])
                2'd0:    w_k = K_BASS;
                2'd1:    w_k = K_MID;
                default: w_k = K_HI;
            endcase
        end
        w_prod = (w_x - w_y) * w_k;
        case (r_idx)
            3'd0:    w_sig = r_ac;
            3'd1:    w_sig = r_lp[0];
            3'd2:    w_sig = r_lp[1] - r_lp[0];
            3'd3:    w_sig = r_lp[2] - r_lp[1];
            default: w_sig = r_ac - r_lp[2];
        endcase
        w_r   = (w_sig + 36'sd32768) >>> 16;
        w_sq  = 64'($signed(w_r[17:0]) * $signed(w_r[17:0]));
        w_acc = {1'b0, r_sum[r_idx]} + {1'b0, w_sq[SUM_W-1:0]};
        w_fl  = (i_floor[r_idx] == '0) ? 10'd1 : i_floor[r_idx];
        case (r_lsel)
            2'd0:    w_v = {16'd0, r_sum[r_idx]};
            2'd1:    w_v = 64'(r_cnt);
            default: w_v = 64'(w_fl);
        endcase
        w_p = '0;
        for (int b = 1; b < 64; b++) if (w_v[b]) w_p = 6'(b);
        w_m0 = (w_p >= 6'd30) ? 32'(w_v >> (w_p - 6'd30)) : 32'(w_v << (6'd30 - w_p));
        w_qprod = 55'(r_num) * 55'(LVL_RECIP);
        w_qest  = w_qprod[LVL_RECIP_SH+9:LVL_RECIP_SH];
        w_rem   = r_num - 34'(r_q) * 34'(LOG2_1E4_Q16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_dc <= '0; r_ac <= '0; r_cnt <= '0; r_outv <= 1'b0;
            r_idx <= '0; r_it <= '0; r_lsel <= '0;
            for (int i = 0; i < 3; i++) r_lp[i] <= '0;
            for (int i = 0; i < NBANDS; i++) begin
                r_sum[i] <= '0; r_sm[i] <= '0;
            end
        end else begin
            if (r_outv && i_res_ready && !w_emit) r_outv <= 1'b0;
            case (r_st)
                S_IDLE: if (i_start) begin
                    r_smp  <= i_item.sample;
                    r_last <= i_item.block_end;
                    r_st   <= S_DC;
                end
                S_DC: begin
                    r_dc  <= r_dc + STATE_W'(w_prod >>> 16);
                    r_ac  <= w_x - (r_dc + STATE_W'(w_prod >>> 16));
                    r_idx <= '0;
                    r_st  <= S_LP;
                end
                S_LP: begin
                    r_lp[r_idx[1:0]] <= w_y + STATE_W'(w_prod >>> 16);
                    if (r_idx == 3'd2) begin
                        r_idx <= '0; r_st <= S_ACC;
                    end else r_idx <= r_idx + 3'd1;
                end
                S_ACC: begin
                    r_sum[r_idx] <= w_acc[SUM_W] ? {SUM_W{1'b1}} : w_acc[SUM_W-1:0];
                    if (r_idx == 3'(NBANDS-1)) begin
                        r_idx <= '0;
                        if (r_cnt < CNT_W'(BLOCK_MAX)) r_cnt <= r_cnt + 1'b1;
                        if (r_last) begin
                            r_st <= S_LOGS; r_lsel <= '0;
                        end else r_st <= S_IDLE;
                    end else r_idx <= r_idx + 3'd1;
                end
                S_LOGS: begin
                    r_m  <= w_m0;
                    r_lr <= LOGQ_W'({w_p, 16'd0});
                    r_it <= '0;
                    r_st <= S_LOGI;
                end
                S_LOGI: begin
                    // one squaring step per cycle
                    logic [63:0] t;
                    t = (64'(r_m) * 64'(r_m)) >> 30;
                    if (t >= 64'h8000_0000) begin
                        r_m <= t[32:1];
                        r_lr[4'd15 - r_it[3:0]] <= 1'b1;
                    end else r_m <= t[31:0];
                    if (r_it == 5'd15) r_st <= S_LVL;
                    r_it <= r_it + 5'd1;
                end
                S_LVL: begin
                    case (r_lsel)
                        2'd0: begin
                            r_lsum <= r_lr; r_lsel <= 2'd1; r_st <= S_LOGS;
                        end
                        2'd1: begin
                            r_lcnt <= r_lr; r_lsel <= 2'd2; r_st <= S_LOGS;
                        end
                        default: begin
                            r_d <= $signed({2'b0, r_lsum}) - $signed({2'b0, r_lcnt})
                                   - $signed({1'b0, r_lr, 1'b0});
                            r_st <= S_DIV;
                        end
                    endcase
                end
                S_DIV: begin
                    r_num <= 34'($unsigned(r_d[LOGQ_W:0])) * 34'd255;
                    r_it  <= 5'd1;
                    r_st  <= S_OUT;
                end
                S_OUT: begin
                    // reciprocal estimate, then one correction step
                    if (r_it == 5'd1) begin
                        r_q  <= w_qest;
                        r_it <= 5'd0;
                    end else begin
                        if (w_rem >= 34'(LOG2_1E4_Q16)) r_q <= r_q + 10'd1;
                        r_st <= S_SMTH;
                    end
                end
                S_SMTH: begin
                    logic [7:0] lv;
                    lv = (r_sum[r_idx] == '0 || r_d <= 0) ? 8'd0 :
                         (r_q > 10'd255) ? 8'd255 : r_q[7:0];
                    r_lv[r_idx] <= lv;
                    if (w_emit) begin
                        for (int i = 0; i < NBANDS; i++) begin
                            logic [7:0] nw;
                            logic [9:0] s;
                            nw = (i == NBANDS-1) ? lv : r_lv[i];
                            s = (nw >= r_sm[i]) ? (10'(nw) * 10'd3 + 10'(r_sm[i]) + 10'd1)
                                : (10'(nw) + 10'(r_sm[i]) * 10'd3 + 10'd1);
                            r_sm[i]  <= s[9:2];
                            r_sum[i] <= '0;
                        end
                        r_cnt  <= '0;
                        r_outv <= 1'b1;
                        r_idx  <= '0;
                        r_st   <= S_IDLE;
                    end else if (r_idx != 3'(NBANDS-1)) begin
                        r_idx  <= r_idx + 3'd1;
                        r_lsel <= '0;
                        r_st   <= S_LOGS;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

[design/audio_band_level_meter_top.sv]
// path: a marked item passes filtering and accumulation, then for each band three logs
// (sum, count, floor) and the scaling before its levels show
// intake: the engine takes no new item until it is done with the last one;
// a marked item holds the back end busy until its levels are emitted
// an untaken result stalls the back end only at its final level step
// synchronous active-low reset clears filters, sums, count and smoothing, and sets floors to defaults
module audio_band_level_meter_top import ablm_pkg::*; #(
    parameter int BLOCK_MAX = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,  // sample
    input  logic                 s_axis_tlast,  // block_end
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata,  // total, bass, mid, hmid, high
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [FLOOR_W-1:0]   i_cfg_data
);
    logic [FLOOR_W-1:0] r_floor [NBANDS];
    logic    w_full, w_empty, w_busy, w_start;
    t_item   w_in, w_q;
    t_levels w_lv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NBANDS; i++) r_floor[i] <= FLOOR_RST[i];
        end else if (i_cfg_we && i_cfg_idx < 3'(NBANDS)) begin
            r_floor[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign s_axis_tready = !w_full;
    assign w_in    = '{sample: s_axis_tdata, block_end: s_axis_tlast};
    assign w_start = !w_empty && !w_busy;

    ablm_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push(s_axis_tvalid && !w_full), .i_data(w_in), .o_full(w_full),
        .i_pop(w_start), .o_empty(w_empty), .o_data(w_q)
    );

    ablm_filter #(.BLOCK_MAX(BLOCK_MAX)) u_filter (
        .i_clk, .i_rst_n, .i_start(w_start), .i_item(w_q), .o_busy(w_busy),
        .i_floor(r_floor), .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .o_levels(w_lv)
    );

    assign m_axis_tdata = {w_lv[4], w_lv[3], w_lv[2], w_lv[1], w_lv[0]};
endmodule
